// ----- sv/des_pkg.sv -----
// des package: permutation tables, s-boxes and key schedule helpers
package des_pkg;

    localparam int unsigned MaxRoundCountDefault = 16;
    localparam int unsigned KeyStoreDepth = 16;

    localparam logic [1:0] CfgKey    = 2'd0;
    localparam logic [1:0] CfgRounds = 2'd1;
    localparam logic [1:0] CfgPerms  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } t_core_state;

    typedef enum logic [0:0] {
        KS_IDLE,
        KS_FILL
    } t_ks_state;

    typedef logic [7:0] t_tab64 [64];
    typedef logic [7:0] t_tab56 [56];
    typedef logic [7:0] t_tab48 [48];
    typedef logic [7:0] t_tab32 [32];
    typedef logic [3:0] t_sbox [8][64];

    localparam t_tab64 TabIp = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    localparam t_tab64 TabFp = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    localparam t_tab48 TabE = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};
    localparam t_tab32 TabP = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
    localparam t_tab56 TabPc1 = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
    localparam t_tab48 TabPc2 = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};
    // one bit per round: 1 means rotate by one, 0 by two
    localparam logic [15:0] ShiftOne = 16'b1000_0001_0000_0011;

    localparam t_sbox TabS = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] perm_ip(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TabIp[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = x[64-int'(TabFp[i])];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] x);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = x[64-int'(TabPc1[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] x);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = x[56-int'(TabPc2[i])];
        return r;
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] e;
        logic [31:0] s;
        logic [5:0]  six;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(TabE[i])];
        e = e ^ k;
        for (int i = 0; i < 8; i++) begin
            six = e[47-6*i -: 6];
            s[31-4*i -: 4] = TabS[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TabP[i])];
        return p;
    endfunction

endpackage

// ----- sv/des_key_sched.sv -----
// des key schedule: one round key per cycle into the round key memory
module des_key_sched
    import des_pkg::*;
#(
    parameter int unsigned KEY_DEPTH = KeyStoreDepth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [63:0]                  i_key,
    output logic                         o_busy,
    output logic                         o_wr_en,
    output logic [$clog2(KEY_DEPTH)-1:0] o_wr_addr,
    output logic [47:0]                  o_wr_data
);
    localparam int unsigned AW = $clog2(KEY_DEPTH);

    t_ks_state         r_state, n_state;
    logic [AW-1:0]     r_idx, n_idx;
    logic [27:0]       r_c, n_c, r_d, n_d;
    logic [27:0]       c_rot, d_rot;
    logic [55:0]       pc1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= KS_FILL;
            r_idx   <= '0;
            r_c     <= '0;
            r_d     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_c     <= n_c;
            r_d     <= n_d;
        end
    end

    always_comb begin
        pc1   = perm_pc1(i_key);
        c_rot = ShiftOne[r_idx] ? {r_c[26:0], r_c[27]} : {r_c[25:0], r_c[27:26]};
        d_rot = ShiftOne[r_idx] ? {r_d[26:0], r_d[27]} : {r_d[25:0], r_d[27:26]};
        n_state   = r_state;
        n_idx     = r_idx;
        n_c       = r_c;
        n_d       = r_d;
        o_wr_en   = 1'b0;
        unique case (r_state)
            KS_IDLE: begin
                if (i_load) begin
                    n_state = KS_FILL;
                    n_idx   = '0;
                    n_c     = pc1[55:28];
                    n_d     = pc1[27:0];
                end
            end
            KS_FILL: begin
                o_wr_en = 1'b1;
                n_c     = c_rot;
                n_d     = d_rot;
                n_idx   = r_idx + 1'b1;
                if (r_idx == AW'(KEY_DEPTH - 1)) n_state = KS_IDLE;
                if (i_load) begin
                    n_state = KS_FILL;
                    n_idx   = '0;
                    n_c     = pc1[55:28];
                    n_d     = pc1[27:0];
                end
            end
            default: n_state = KS_IDLE;
        endcase
    end

    assign o_busy    = (r_state == KS_FILL) || i_load;
    assign o_wr_addr = r_idx;
    assign o_wr_data = perm_pc2({c_rot, d_rot});
endmodule

// ----- sv/des_round_core.sv -----
// des round engine: round key memory and one feistel round per cycle
module des_round_core
    import des_pkg::*;
#(
    parameter int unsigned KEY_DEPTH = KeyStoreDepth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [$clog2(KEY_DEPTH)-1:0] i_wr_addr,
    input  logic [47:0]                  i_wr_data,
    input  logic                         i_start,
    input  logic [63:0]                  i_block,
    input  logic                         i_decrypt,
    input  logic [$clog2(KEY_DEPTH):0]   i_rounds,
    input  logic                         i_perms,
    output logic                         o_busy,
    output logic                         o_valid,
    output logic [63:0]                  o_block
);
    localparam int unsigned AW = $clog2(KEY_DEPTH);

    logic [47:0]   r_mem [KEY_DEPTH];
    logic [47:0]   r_rd_data;
    t_core_state   r_state, n_state;
    logic [AW-1:0] r_kidx, n_kidx, rd_addr;
    logic [AW:0]   r_left, n_left;
    logic          r_dec, r_perms;
    logic [31:0]   r_l, r_r, n_l, n_r;
    logic [63:0]   ip_blk, fin;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_kidx <= n_kidx;
        r_left <= n_left;
        r_l    <= n_l;
        r_r    <= n_r;
        if (i_start && r_state == ST_IDLE) begin
            r_dec   <= i_decrypt;
            r_perms <= i_perms;
        end
    end

    always_comb begin
        ip_blk  = i_perms ? perm_ip(i_block) : i_block;
        n_state = r_state;
        n_kidx  = r_kidx;
        n_left  = r_left;
        n_l     = r_l;
        n_r     = r_r;
        rd_addr = r_kidx;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_LOAD;
                    n_l     = ip_blk[63:32];
                    n_r     = ip_blk[31:0];
                    n_left  = i_rounds;
                    n_kidx  = i_decrypt ? AW'(i_rounds - 1'b1) : '0;
                end
            end
            ST_LOAD: begin
                // key for first round is being read
                n_state = ST_ROUND;
                n_kidx  = r_dec ? r_kidx - 1'b1 : r_kidx + 1'b1;
            end
            ST_ROUND: begin
                n_l    = r_r;
                n_r    = r_l ^ feistel(r_r, r_rd_data);
                n_left = r_left - 1'b1;
                n_kidx = r_dec ? r_kidx - 1'b1 : r_kidx + 1'b1;
                if (r_left == (AW+1)'(1)) n_state = ST_DONE;
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign fin     = {r_r, r_l};
    assign o_block = r_perms ? perm_fp(fin) : fin;
    assign o_valid = (r_state == ST_DONE);
    assign o_busy  = (r_state != ST_IDLE);
endmodule

// ----- sv/des_block_cipher.sv -----
// des block cipher top level: configuration registers, key schedule and round engine
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------
//  input    | start / busy        | i_block_in, i_mode
//  result   | o_valid (strobe)    | o_block_out
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// from start to the result strobe a word passes the load state, where the first round
// key is read from the key memory, then the round state with one feistel round per
// cycle, then the done state that gives the output strobe
// after reset and after every key write the key schedule fills every entry of the
// round key memory; busy stays high meanwhile
// the receiver cannot stall; o_valid is high for exactly one cycle
module des_block_cipher
    import des_pkg::*;
#(
    parameter int unsigned MAX_ROUND_COUNT = MaxRoundCountDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_block_in,
    input  logic        i_mode,
    output logic        o_valid,
    output logic [63:0] o_block_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    localparam int unsigned AW = $clog2(KeyStoreDepth);

    logic [4:0]  r_rounds;
    logic        r_perms;
    logic        key_wr, ks_busy, core_busy;
    logic        mem_wr;
    logic [AW-1:0] mem_addr;
    logic [47:0] mem_data;
    logic [AW:0] eff_rounds;

    // config writes always taken; key write restarts the schedule
    assign o_cfg_ready = 1'b1;
    assign key_wr = i_cfg_valid && (i_cfg_index == CfgKey);

    // the key itself goes straight into the schedule, nothing else keeps it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rounds <= 5'd16;
            r_perms  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CfgRounds: r_rounds <= i_cfg_data[4:0];
                CfgPerms:  r_perms  <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    // clamp round count to 1..MAX_ROUND_COUNT
    always_comb begin
        if (r_rounds == 5'd0) eff_rounds = (AW+1)'(1);
        else if (32'(r_rounds) > MAX_ROUND_COUNT) eff_rounds = (AW+1)'(MAX_ROUND_COUNT);
        else eff_rounds = (AW+1)'(r_rounds);
    end

    des_key_sched #(.KEY_DEPTH(KeyStoreDepth)) u_ks (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (key_wr),
        .i_key     (i_cfg_data),
        .o_busy    (ks_busy),
        .o_wr_en   (mem_wr),
        .o_wr_addr (mem_addr),
        .o_wr_data (mem_data)
    );

    des_round_core #(.KEY_DEPTH(KeyStoreDepth)) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_wr),
        .i_wr_addr (mem_addr),
        .i_wr_data (mem_data),
        .i_start   (start && !busy),
        .i_block   (i_block_in),
        .i_decrypt (i_mode),
        .i_rounds  (eff_rounds),
        .i_perms   (r_perms),
        .o_busy    (core_busy),
        .o_valid   (o_valid),
        .o_block   (o_block_out)
    );

    assign busy = core_busy || ks_busy;
endmodule

// ----- tb/sv/des_block_cipher_test.sv -----
// testbench for the des block cipher: directed vectors, then random words checked against a local model
`timescale 1ns / 100ps

module des_block_cipher_test;
    import des_pkg::*;

    localparam int unsigned CycleLimit = 400000;
    localparam int unsigned WordsPerPhase = 165;
    localparam int unsigned NumPhases = 8;
    localparam int unsigned DrainCycles = 40;

    // directed stimulus row: key to load first, input word, optional typed-in answer
    typedef struct {
        logic [63:0] key;
        logic [63:0] blk;
        logic        dec;
        logic        known;
        logic [63:0] want;
    } t_vector;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [63:0] i_block_in;
    logic        i_mode;
    logic        o_valid;
    logic [63:0] o_block_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    // local copy of the block's registers and key store
    logic [63:0] key_reg;
    logic [4:0]  rounds_reg;
    logic        perms_reg;
    logic [47:0] sub_keys [16];

    logic [63:0] pending_blocks [$];
    int unsigned fail_count;
    int unsigned cycle_count;

    t_vector vectors [13];

    des_block_cipher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_block_in  (i_block_in),
        .i_mode      (i_mode),
        .o_valid     (o_valid),
        .o_block_out (o_block_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // key schedule: pc-1, rotate both halves by one or two, pc-2
    function automatic void derive_sub_keys(input logic [63:0] key);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [55:0] joined;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64-int'(TabPc1[i])];
        c = cd[55:28];
        d = cd[27:0];
        for (int n = 0; n < 16; n++) begin
            // rounds 1, 2, 9 and 16 rotate by one, the rest by two
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
            if (!(n == 0 || n == 1 || n == 8 || n == 15)) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            joined = {c, d};
            for (int i = 0; i < 48; i++) sub_keys[n][47-i] = joined[56-int'(TabPc2[i])];
        end
    endfunction

    function automatic logic [31:0] round_mix(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] e;
        logic [5:0]  six;
        logic [31:0] s;
        logic [31:0] p;
        for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(TabE[i])];
        e ^= k;
        for (int i = 0; i < 8; i++) begin
            six = e[47-6*i -: 6];
            s[31-4*i -: 4] = TabS[i][{six[5], six[0]} * 16 + six[4:1]];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32-int'(TabP[i])];
        return p;
    endfunction

    function automatic logic [63:0] cipher_word(input logic [63:0] blk, input logic dec);
        int unsigned n;
        int unsigned ki;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        logic [63:0] x;
        logic [63:0] y;
        // round count zero runs one round, above the maximum saturates
        n = rounds_reg;
        if (n < 1) n = 1;
        if (n > MaxRoundCountDefault) n = MaxRoundCountDefault;
        x = blk;
        if (perms_reg) for (int i = 0; i < 64; i++) x[63-i] = blk[64-int'(TabIp[i])];
        l = x[63:32];
        r = x[31:0];
        for (int i = 0; i < n; i++) begin
            ki = dec ? (n - 1 - i) : i;
            t = r;
            r = l ^ round_mix(r, sub_keys[ki]);
            l = t;
        end
        // final swap, then fp when outer permutations are on
        x = {r, l};
        y = x;
        if (perms_reg) for (int i = 0; i < 64; i++) y[63-i] = x[64-int'(TabFp[i])];
        return y;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch: %s got %h want %h at cycle %0d", what, got, want, cycle_count);
        fail_count++;
    endtask

    // register write; the model follows at the accepting edge
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CfgKey: begin
                key_reg = data;
                derive_sub_keys(data);
            end
            CfgRounds: rounds_reg = data[4:0];
            CfgPerms:  perms_reg = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // present one word; start stays high if the next word follows at once
    task automatic send_word(input logic [63:0] blk, input logic dec, input logic known,
                             input logic [63:0] want);
        logic [63:0] model;
        @(negedge i_clk);
        start      = 1'b1;
        i_block_in = blk;
        i_mode     = dec;
        do @(posedge i_clk); while (busy);
        model = cipher_word(blk, dec);
        if (known && model !== want) report_mismatch("known vector", model, want);
        pending_blocks.push_back(known ? want : model);
    endtask

    task automatic sender_gap(input int unsigned pct);
        while ($urandom_range(99) < pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
    endtask

    // hold off until every expected word has come back
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // result checker and cycle watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n && o_valid) begin
            if (pending_blocks.size() == 0) begin
                report_mismatch("unexpected word", o_block_out, 64'h0);
            end else begin
                if (o_block_out !== pending_blocks[0])
                    report_mismatch("block_out", o_block_out, pending_blocks[0]);
                void'(pending_blocks.pop_front());
            end
        end
    end

    initial begin
        logic [63:0] k;
        logic [4:0]  rounds_pick [NumPhases];
        int unsigned pct_pick [NumPhases];

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_block_in = '0;
        i_mode = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CfgKey;
        i_cfg_data = '0;
        fail_count = 0;
        cycle_count = 0;

        // state after reset: key zero, sixteen rounds, outer perms on
        key_reg = '0;
        rounds_reg = 5'd16;
        perms_reg = 1'b1;
        derive_sub_keys('0);

        // well-known des vectors mixed with extremes checked by the model
        vectors = '{
            '{64'h0, 64'h0, 1'b0, 1'b1, 64'h8CA64DE9C1B123A7},
            '{64'h0, 64'h8CA64DE9C1B123A7, 1'b1, 1'b1, 64'h0},
            '{64'h0, 64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0, 64'h0},
            '{64'h0, 64'hFFFFFFFFFFFFFFFF, 1'b1, 1'b0, 64'h0},
            '{64'h0, 64'h8000000000000000, 1'b0, 1'b0, 64'h0},
            '{64'h0, 64'h0000000000000001, 1'b1, 1'b0, 64'h0},
            '{64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b1, 64'h7359B2163E4EDC58},
            '{64'hFFFFFFFFFFFFFFFF, 64'hAAAAAAAAAAAAAAAA, 1'b0, 1'b0, 64'h0},
            '{64'hFFFFFFFFFFFFFFFF, 64'h5555555555555555, 1'b1, 1'b0, 64'h0},
            '{64'h133457799BBCDFF1, 64'h0123456789ABCDEF, 1'b0, 1'b1, 64'h85E813540F0AB405},
            '{64'h133457799BBCDFF1, 64'h85E813540F0AB405, 1'b1, 1'b1, 64'h0123456789ABCDEF},
            '{64'h133457799BBCDFF1, 64'h0, 1'b1, 1'b0, 64'h0},
            '{64'h133457799BBCDFF1, 64'hFFFFFFFFFFFFFFFF, 1'b0, 1'b0, 64'h0}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (vectors[i]) begin
            if (vectors[i].key !== key_reg) begin
                settle();
                write_reg(CfgKey, vectors[i].key);
            end
            send_word(vectors[i].blk, vectors[i].dec, vectors[i].known, vectors[i].want);
        end

        // round counts cover one, sixteen, zero and values past the maximum
        rounds_pick = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd16, 5'd9};
        pct_pick    = '{0, 83, 14, 0, 83, 14, 0, 83};

        for (int ph = 0; ph < NumPhases; ph++) begin
            settle();
            k = {$urandom, $urandom};
            if (ph == 3) k = '0;
            if (ph == 6) k = '1;
            write_reg(CfgKey, k);
            write_reg(CfgRounds, {59'h0, rounds_pick[ph]});
            write_reg(CfgPerms, {$urandom, $urandom} & ~64'h1 | 64'(ph % 2 == 0));
            // index past the register list must change nothing
            if (ph == 2) write_reg(2'd3, {$urandom, $urandom});
            for (int n = 0; n < WordsPerPhase; n++) begin
                sender_gap(pct_pick[ph]);
                if (ph == 1 && n == WordsPerPhase / 2) settle();
                send_word({$urandom, $urandom}, 1'($urandom), 1'b0, 64'h0);
            end
        end

        settle();
        if (pending_blocks.size() != 0)
            report_mismatch("words never returned", 64'(pending_blocks.size()), 64'h0);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/des_pkg.sv
sv/des_key_sched.sv
sv/des_round_core.sv
sv/des_block_cipher.sv
tb/sv/des_block_cipher_test.sv
